### rtl/core/fas_pkg.sv
// Package: shared types and constants for the truncating float adder/subtractor.
package fas_pkg;

    localparam int WordW = 32;
    localparam int ExpW = 8;
    localparam int FracW = 23;
    localparam int ManW = 24;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    // Stage 1 to stage 2: aligned, signed mantissas
    typedef struct packed {
        logic        bypass;
        logic [31:0] bypass_val;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [7:0]  exp;
    } align_t;

    // Stage 2 to stage 3: magnitude of the sum
    typedef struct packed {
        logic        bypass;
        logic [31:0] bypass_val;
        logic        sgn;
        logic [31:0] mag;
        logic [7:0]  exp;
    } mag_t;

endpackage

### rtl/core/fas_align.sv
// Module: operand preparation, exponent compare and mantissa alignment.
module fas_align
(
    input  logic               op,
    input  logic [31:0]        operand_a,
    input  logic [31:0]        operand_b,
    output fas_pkg::align_t    result
);

    logic [31:0] b_eff;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [7:0]  d;
    logic [23:0] ma_sh;
    logic [23:0] mb_sh;

    // Negate b for subtract (+0 and -0 both give +0)
    always_comb
    begin
        b_eff = operand_b;
        if (op == fas_pkg::OP_SUB)
        begin
            if (operand_b[31])
                b_eff = {1'b0, operand_b[30:0]};
            else if (operand_b != 32'd0)
                b_eff = {1'b1, operand_b[30:0]};
        end
    end

    assign ma = {1'b1, operand_a[22:0]};
    assign mb = {1'b1, b_eff[22:0]};
    assign ea = operand_a[30:23];
    assign eb = b_eff[30:23];

    // Align the smaller exponent
    always_comb
    begin
        ma_sh = ma;
        mb_sh = mb;
        if (ea < eb)
        begin
            d = eb - ea;
            ma_sh = (d >= 8'd24) ? 24'd0 : (ma >> d[4:0]);
            result.exp = eb;
        end
        else
        begin
            d = ea - eb;
            mb_sh = (d >= 8'd24) ? 24'd0 : (mb >> d[4:0]);
            result.exp = ea;
        end
        result.ma = operand_a[31] ? (32'd0 - {8'd0, ma_sh}) : {8'd0, ma_sh};
        result.mb = b_eff[31] ? (32'd0 - {8'd0, mb_sh}) : {8'd0, mb_sh};
    end

    // Early-out cases
    always_comb
    begin
        result.bypass = 1'b1;
        result.bypass_val = 32'd0;
        if (op == fas_pkg::OP_SUB && operand_a == operand_b)
            result.bypass_val = 32'd0;
        else if (operand_a == 32'd0)
            result.bypass_val = b_eff;
        else if (b_eff == 32'd0)
            result.bypass_val = operand_a;
        else
            result.bypass = 1'b0;
    end

endmodule

### rtl/core/fas_norm.sv
// Module: leading-one search and normalization of the sum magnitude.
module fas_norm
(
    input  fas_pkg::mag_t  m,
    output logic [31:0]    sum_bits
);

    logic [4:0]  top;
    logic [31:0] frac;
    logic [7:0]  e;

    // Leading one position
    always_comb
    begin
        top = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (m.mag[i])
                top = 5'(i);
        end
    end

    always_comb
    begin
        if (top >= 5'd23)
        begin
            frac = m.mag >> (top - 5'd23);
            e = m.exp + {3'd0, top - 5'd23};
        end
        else
        begin
            frac = m.mag << (5'd23 - top);
            e = m.exp - {3'd0, 5'd23 - top};
        end
        if (m.bypass)
            sum_bits = m.bypass_val;
        else if (m.mag == 32'd0)
            sum_bits = 32'd0;
        else
            sum_bits = {m.sgn, e, frac[22:0]};
    end

endmodule

### rtl/core/float32_add_sub_truncating.sv
// Top level: pipelined truncating single-precision adder/subtractor.
// Usage:
//   Slave channel s_axis_* carries one transaction per operation:
//   tdata = {operand_b, operand_a, op} packed from bit 0, zero-filled to 72 bits.
//   Master channel m_axis_* returns one transaction per input with tdata = sum_bits.
//   Throughput: one transaction per cycle while the receiver keeps m_axis_tready
//   high; the pipeline is a chain of three register stages (align,
//   add/magnitude, normalize+output), and m_axis_tvalid comes from the last.
//   Reset (rst_n low) clears all valid bits; payload registers are not reset.
//   When the receiver stalls, stages fill up; a stage advances only when the
//   stage after it is empty or moving, so nothing is lost or repeated.
//   s_axis_tready drops only once every stage holds a transaction.
module float32_add_sub_truncating
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [0] op, [32:1] operand_a, [64:33] operand_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] sum_bits
);

    fas_pkg::align_t al;
    fas_pkg::align_t s1_reg;
    fas_pkg::mag_t   s2_reg;
    fas_pkg::mag_t   mag_next;
    logic [31:0]     sum_next;
    logic [31:0]     out_reg;
    logic            v1_reg;
    logic            v2_reg;
    logic            v3_reg;
    logic            adv1;
    logic            adv2;
    logic            adv3;
    logic [31:0]     s;

    // Pipeline handshake
    assign adv3 = !v3_reg || m_axis_tready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign s_axis_tready = adv1;
    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata = out_reg;

    fas_align u_align
    (
        .op        (s_axis_tdata[0]),
        .operand_a (s_axis_tdata[32:1]),
        .operand_b (s_axis_tdata[64:33]),
        .result    (al)
    );

    // Add and take magnitude
    always_comb
    begin
        s = s1_reg.ma + s1_reg.mb;
        mag_next.bypass = s1_reg.bypass;
        mag_next.bypass_val = s1_reg.bypass_val;
        mag_next.sgn = s[31];
        mag_next.mag = s[31] ? (32'd0 - s) : s;
        mag_next.exp = s1_reg.exp;
    end

    fas_norm u_norm
    (
        .m        (s2_reg),
        .sum_bits (sum_next)
    );

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= s_axis_tvalid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv1)
            s1_reg <= al;
        if (adv2)
            s2_reg <= mag_next;
        if (adv3)
            out_reg <= sum_next;
    end

endmodule

### rtl/core/fas_checker.sv
// Checker: port-level assertions for the adder/subtractor, with bind.
module fas_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Output empty means input is ready
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("ready low with empty output");

    // Nothing comes out without an earlier input
    a_nogen: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!s_axis_tvalid, 3) && $past(!s_axis_tvalid, 2) && $past(!s_axis_tvalid, 1)
        && $past(!m_axis_tvalid) |-> !m_axis_tvalid)
        else $error("result invented");

endmodule

bind float32_add_sub_truncating fas_checker u_fas_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
